>>> sv/aabb_frustum_cull_defines.svh
// Assertion macros used by the culling block's top level.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// Consequent must hold a fixed number of cycles after the antecedent.
`define AFC_ASSERT_DELAY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/afc_pkg.sv
// Shared types and constants for the box versus frustum culling block.
package afc_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int PLANE_COUNT_DEF = 6;
  localparam int NUM_PLANES      = 6;
  localparam int AXES            = 3;
  localparam int FIELD_BITS      = 16;
  localparam int PLANE_BITS      = 64;
  localparam int MARGIN_BITS     = 15;
  localparam int ID_BITS         = 16;
  localparam int CFG_INDEX_BITS  = 3;
  // Plane offset d is Q.4; products are Q.18, so d is shifted up by 14.
  localparam int D_SHIFT         = 14;
  localparam int D_LSB           = 3 * FIELD_BITS;

  // Widened coordinate width: the larger of the coordinate and margin range, plus one.
  function automatic int value_bits(input int coord_bits);
    return ((coord_bits > MARGIN_BITS + 1) ? coord_bits : MARGIN_BITS + 1) + 1;
  endfunction

  localparam int VALUE_BITS_DEF = value_bits(COORD_BITS_DEF);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5,
    REG_CULL_MARGIN  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic               valid;
    logic               vis;
    logic               last;
    logic [ID_BITS-1:0] id;
  } ctl_t;

endpackage

>>> sv/afc_widen.sv
// Entry stage: registers an accepted box widened by the cull margin on every side.
module afc_widen #(
  parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF,
  parameter int VW         = afc_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic signed [COORD_BITS-1:0]        box_min [afc_pkg::AXES],
  input  logic signed [COORD_BITS-1:0]        box_max [afc_pkg::AXES],
  input  logic [afc_pkg::ID_BITS-1:0]         chunk_id,
  input  logic                                last_chunk,
  input  logic [afc_pkg::MARGIN_BITS-1:0]     margin,
  output afc_pkg::ctl_t                       out_ctl,
  output logic signed [VW-1:0]                out_lo [afc_pkg::AXES],
  output logic signed [VW-1:0]                out_hi [afc_pkg::AXES]
);

  logic signed [VW-1:0] margin_ext;
  logic signed [VW-1:0] lo_next [afc_pkg::AXES];
  logic signed [VW-1:0] hi_next [afc_pkg::AXES];

  assign margin_ext = $signed(VW'(margin));

  always_comb begin
    for (int a = 0; a < afc_pkg::AXES; a++) begin
      lo_next[a] = VW'(box_min[a]) - margin_ext;
      hi_next[a] = VW'(box_max[a]) + margin_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= take;
    end
    out_ctl.vis  <= 1'b1;
    out_ctl.last <= last_chunk;
    out_ctl.id   <= chunk_id;
    out_lo       <= lo_next;
    out_hi       <= hi_next;
  end

endmodule

>>> sv/afc_cell.sv
// One plane test cell: multiply stage, then sum and sign stage, handing the box onward.
module afc_cell #(
  parameter int VW = afc_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [afc_pkg::PLANE_BITS-1:0]      plane,
  input  afc_pkg::ctl_t                       in_ctl,
  input  logic signed [VW-1:0]                in_lo [afc_pkg::AXES],
  input  logic signed [VW-1:0]                in_hi [afc_pkg::AXES],
  output afc_pkg::ctl_t                       out_ctl,
  output logic signed [VW-1:0]                out_lo [afc_pkg::AXES],
  output logic signed [VW-1:0]                out_hi [afc_pkg::AXES]
);

  localparam int PW = afc_pkg::FIELD_BITS + VW;
  localparam int SW = PW + 2;

  logic signed [afc_pkg::FIELD_BITS-1:0] nrm [afc_pkg::AXES];
  logic signed [VW-1:0]                  vtx [afc_pkg::AXES];
  logic signed [PW-1:0]                  prod_next [afc_pkg::AXES];

  afc_pkg::ctl_t                         ctl1;
  logic signed [VW-1:0]                  lo1 [afc_pkg::AXES];
  logic signed [VW-1:0]                  hi1 [afc_pkg::AXES];
  logic signed [PW-1:0]                  prod [afc_pkg::AXES];
  logic signed [afc_pkg::FIELD_BITS-1:0] d1;

  logic signed [SW-1:0]                  sum;
  logic                                  vis_next;

  // Positive vertex: the max corner where the normal is zero or positive.
  always_comb begin
    for (int a = 0; a < afc_pkg::AXES; a++) begin
      nrm[a]       = $signed(plane[a*afc_pkg::FIELD_BITS +: afc_pkg::FIELD_BITS]);
      vtx[a]       = nrm[a][afc_pkg::FIELD_BITS-1] ? in_lo[a] : in_hi[a];
      prod_next[a] = PW'(nrm[a]) * PW'(vtx[a]);
    end
  end

  assign sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2])
             + (SW'(d1) <<< afc_pkg::D_SHIFT);
  assign vis_next = ctl1.vis & ~sum[SW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid    <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else begin
      ctl1.valid    <= in_ctl.valid;
      out_ctl.valid <= ctl1.valid;
    end
    ctl1.vis     <= in_ctl.vis;
    ctl1.last    <= in_ctl.last;
    ctl1.id      <= in_ctl.id;
    lo1          <= in_lo;
    hi1          <= in_hi;
    prod         <= prod_next;
    d1           <= $signed(plane[afc_pkg::D_LSB +: afc_pkg::FIELD_BITS]);
    out_ctl.vis  <= vis_next;
    out_ctl.last <= ctl1.last;
    out_ctl.id   <= ctl1.id;
    out_lo       <= lo1;
    out_hi       <= hi1;
  end

endmodule

>>> sv/aabb_frustum_cull.sv
// Top level of the box versus view-frustum culling block.
//
// Boxes enter on the command channel: a box with its chunk id and last marker
// is taken at a clock edge where start is high and busy is low. busy is high
// only while rst is asserted, so one box can be taken every cycle.
// Each box produces exactly one transaction on the result side: done is high
// for one cycle with visible, out_chunk_id and out_last. Results leave in
// input order. Throughput is one box per cycle outside reset; each box
// passes through the margin stage and then a chain of plane cells, each a
// multiply stage followed by a sum and sign stage. The receiver cannot hold
// results off and need not.
// Planes and the margin are written on the cfg channel (index 0..5 planes,
// 6 margin; index 7 is ignored); cfg_ready is always high. Write them only
// while no box is in flight.
// Reset clears all planes and the margin to zero and empties the pipeline;
// an all-zero plane never culls.
`include "aabb_frustum_cull_defines.svh"

module aabb_frustum_cull #(
  parameter int COORD_BITS  = afc_pkg::COORD_BITS_DEF,
  parameter int PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          box_min_x,
  input  logic signed [COORD_BITS-1:0]          box_min_y,
  input  logic signed [COORD_BITS-1:0]          box_min_z,
  input  logic signed [COORD_BITS-1:0]          box_max_x,
  input  logic signed [COORD_BITS-1:0]          box_max_y,
  input  logic signed [COORD_BITS-1:0]          box_max_z,
  input  logic [afc_pkg::ID_BITS-1:0]           chunk_id,
  input  logic                                  last_chunk,
  output logic                                  done,
  output logic                                  visible,
  output logic [afc_pkg::ID_BITS-1:0]           out_chunk_id,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [afc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [afc_pkg::PLANE_BITS-1:0]        cfg_data
);

  localparam int VW      = afc_pkg::value_bits(COORD_BITS);
  localparam int LATENCY = 1 + 2 * PLANE_COUNT;

  logic [afc_pkg::PLANE_BITS-1:0]  plane_regs [afc_pkg::NUM_PLANES];
  logic [afc_pkg::MARGIN_BITS-1:0] margin;

  logic signed [COORD_BITS-1:0]    box_min [afc_pkg::AXES];
  logic signed [COORD_BITS-1:0]    box_max [afc_pkg::AXES];
  logic                            take;

  afc_pkg::ctl_t                   ctl_chain [PLANE_COUNT+1];
  logic signed [VW-1:0]            lo_chain  [PLANE_COUNT+1][afc_pkg::AXES];
  logic signed [VW-1:0]            hi_chain  [PLANE_COUNT+1][afc_pkg::AXES];

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign take      = start & ~busy;

  assign box_min[0] = box_min_x;
  assign box_min[1] = box_min_y;
  assign box_min[2] = box_min_z;
  assign box_max[0] = box_max_x;
  assign box_max[1] = box_max_y;
  assign box_max[2] = box_max_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
        plane_regs[i] <= '0;
      end
      margin <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (afc_pkg::reg_idx_t'(cfg_index))
        afc_pkg::REG_PLANE_LEFT, afc_pkg::REG_PLANE_RIGHT, afc_pkg::REG_PLANE_BOTTOM,
        afc_pkg::REG_PLANE_TOP, afc_pkg::REG_PLANE_NEAR, afc_pkg::REG_PLANE_FAR: begin
          plane_regs[cfg_index] <= cfg_data;
        end
        afc_pkg::REG_CULL_MARGIN: begin
          margin <= cfg_data[afc_pkg::MARGIN_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  afc_widen #(
    .COORD_BITS (COORD_BITS),
    .VW         (VW)
  ) u_widen (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .box_min    (box_min),
    .box_max    (box_max),
    .chunk_id   (chunk_id),
    .last_chunk (last_chunk),
    .margin     (margin),
    .out_ctl    (ctl_chain[0]),
    .out_lo     (lo_chain[0]),
    .out_hi     (hi_chain[0])
  );

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
    afc_cell #(
      .VW      (VW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .plane   (plane_regs[p]),
      .in_ctl  (ctl_chain[p]),
      .in_lo   (lo_chain[p]),
      .in_hi   (hi_chain[p]),
      .out_ctl (ctl_chain[p+1]),
      .out_lo  (lo_chain[p+1]),
      .out_hi  (hi_chain[p+1])
    );
  end

  assign done         = ctl_chain[PLANE_COUNT].valid;
  assign visible      = ctl_chain[PLANE_COUNT].vis;
  assign out_chunk_id = ctl_chain[PLANE_COUNT].id;
  assign out_last     = ctl_chain[PLANE_COUNT].last;

  `AFC_ASSERT_DELAY(a_result_latency, take, LATENCY, done, "box taken without result at fixed latency")
  `AFC_ASSERT_DELAY(a_id_order, take, LATENCY, out_chunk_id == $past(chunk_id, LATENCY), "result chunk id does not match the box taken")
  `AFC_ASSERT_NEXT(a_margin_write, cfg_valid && cfg_ready && cfg_index == afc_pkg::REG_CULL_MARGIN, margin == $past(cfg_data[afc_pkg::MARGIN_BITS-1:0]), "margin register not updated by write")

endmodule

>>> dv/aabb_frustum_cull_tb.sv
// Self-checking testbench for the box versus view-frustum culling block.
module aabb_frustum_cull_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int PIPE_DEPTH = 1 + 2 * PLANE_COUNT_DEF;
  localparam int NUM_PHASES = 10;
  localparam int BOXES_PER_PHASE = 200;
  localparam int QUIET_PHASE = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_z;
    logic [ID_BITS-1:0]   id;
    logic                 last;
  } box_t;

  typedef struct packed {
    logic               vis;
    logic [ID_BITS-1:0] id;
    logic               last;
  } cull_res_t;

  typedef struct {
    bit                        is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [PLANE_BITS-1:0]     data;
    box_t                      box;
    bit                        typed;
    bit                        vis;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  box_t box_drv = '0;
  logic done;
  logic visible;
  logic [ID_BITS-1:0] out_chunk_id;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [PLANE_BITS-1:0] cfg_data = '0;

  // Hand-written expectation that travels with the box of a directed row.
  bit typed_valid = 1'b0;
  bit typed_vis = 1'b0;

  bit idle_on = 1'b1;
  int fail_count = 0;

  logic [PLANE_BITS-1:0] plane_shadow[NUM_PLANES];
  logic [MARGIN_BITS-1:0] margin_shadow;
  cull_res_t cull_q[$];
  dir_row_t dir_table[$];

  aabb_frustum_cull i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .box_min_x    (box_drv.min_x),
    .box_min_y    (box_drv.min_y),
    .box_min_z    (box_drv.min_z),
    .box_max_x    (box_drv.max_x),
    .box_max_y    (box_drv.max_y),
    .box_max_z    (box_drv.max_z),
    .chunk_id     (box_drv.id),
    .last_chunk   (box_drv.last),
    .done         (done),
    .visible      (visible),
    .out_chunk_id (out_chunk_id),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Positive-vertex test against the shadow copy of the planes and margin.
  function automatic logic box_in_view(input box_t b);
    longint lo[AXES];
    longint hi[AXES];
    longint n;
    longint sum;
    logic [PLANE_BITS-1:0] pl;
    logic vis;
    vis = 1'b1;
    lo[0] = longint'($signed(b.min_x)) - longint'(margin_shadow);
    lo[1] = longint'($signed(b.min_y)) - longint'(margin_shadow);
    lo[2] = longint'($signed(b.min_z)) - longint'(margin_shadow);
    hi[0] = longint'($signed(b.max_x)) + longint'(margin_shadow);
    hi[1] = longint'($signed(b.max_y)) + longint'(margin_shadow);
    hi[2] = longint'($signed(b.max_z)) + longint'(margin_shadow);
    for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
      pl = plane_shadow[p];
      sum = longint'($signed(pl[D_LSB +: FIELD_BITS])) * (longint'(1) << D_SHIFT);
      for (int a = 0; a < AXES; a++) begin
        n = longint'($signed(pl[a*FIELD_BITS +: FIELD_BITS]));
        sum += n * ((n >= 0) ? hi[a] : lo[a]);
      end
      if (sum < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  always @(posedge clk) begin
    cull_res_t want;
    if (!rst) begin
      if (done) begin
        if (cull_q.size() == 0) begin
          fail_count++;
          $display("%0t: result for chunk %h with no box outstanding", $time, out_chunk_id);
        end else begin
          want = cull_q.pop_front();
          if (visible !== want.vis) begin
            fail_count++;
            $display("%0t: visible expected %b actual %b (chunk %h)",
                     $time, want.vis, visible, want.id);
          end
          if (out_chunk_id !== want.id) begin
            fail_count++;
            $display("%0t: out_chunk_id expected %h actual %h", $time, want.id, out_chunk_id);
          end
          if (out_last !== want.last) begin
            fail_count++;
            $display("%0t: out_last expected %b actual %b (chunk %h)",
                     $time, want.last, out_last, want.id);
          end
        end
      end
      if (start && !busy) begin
        want.vis = typed_valid ? typed_vis : box_in_view(box_drv);
        want.id = box_drv.id;
        want.last = box_drv.last;
        cull_q.insert(cull_q.size(), want);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < NUM_PLANES) plane_shadow[cfg_index] = cfg_data;
        else if (cfg_index == REG_CULL_MARGIN) margin_shadow = cfg_data[MARGIN_BITS-1:0];
      end
    end
  end

  function automatic logic [PLANE_BITS-1:0] plane_word(input int nx, input int ny,
                                                       input int nz, input int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic box_t mk_box(input int mnx, input int mny, input int mnz, input int mxx,
                                  input int mxy, input int mxz, input int id, input bit last);
    box_t b;
    b.min_x = CW'(mnx);
    b.min_y = CW'(mny);
    b.min_z = CW'(mnz);
    b.max_x = CW'(mxx);
    b.max_y = CW'(mxy);
    b.max_z = CW'(mxz);
    b.id = ID_BITS'(id);
    b.last = last;
    return b;
  endfunction

  task automatic add_box(input box_t b, input bit typed, input bit vis);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.data = '0;
    r.box = b;
    r.typed = typed;
    r.vis = vis;
    dir_table.insert(dir_table.size(), r);
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [PLANE_BITS-1:0] data);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    r.box = '0;
    r.typed = 1'b0;
    r.vis = 1'b0;
    dir_table.insert(dir_table.size(), r);
  endtask

  // Half the planes get a random normal with a positive offset, so boxes near the
  // origin land on both sides; the rest are disabled or fully random.
  function automatic logic [PLANE_BITS-1:0] rand_plane();
    logic [PLANE_BITS-1:0] w;
    case ($urandom_range(3))
      0: w = '0;
      1: w = {$urandom, $urandom};
      default: w = {16'($urandom_range(8191)), 16'($urandom), 16'($urandom), 16'($urandom)};
    endcase
    return w;
  endfunction

  function automatic box_t rand_box();
    box_t b;
    int lo[AXES];
    int hi[AXES];
    int c;
    int e;
    int t;
    b.id = ID_BITS'($urandom);
    b.last = ($urandom_range(7) == 0);
    if ($urandom_range(3) == 0) begin
      b.min_x = CW'($urandom);
      b.min_y = CW'($urandom);
      b.min_z = CW'($urandom);
      b.max_x = CW'($urandom);
      b.max_y = CW'($urandom);
      b.max_z = CW'($urandom);
    end else begin
      for (int a = 0; a < AXES; a++) begin
        c = int'($urandom_range(4095)) - 2048;
        e = int'($urandom_range(256));
        lo[a] = c - e;
        hi[a] = c + e;
        // Occasionally hand over an inverted box.
        if ($urandom_range(15) == 0) begin
          t = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
      b.min_x = CW'(lo[0]);
      b.min_y = CW'(lo[1]);
      b.min_z = CW'(lo[2]);
      b.max_x = CW'(hi[0]);
      b.max_y = CW'(hi[1]);
      b.max_z = CW'(hi[2]);
    end
    return b;
  endfunction

  task automatic send_box(input box_t b, input bit typed, input bit vis);
    cfg_valid <= 1'b0;
    if (idle_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    box_drv <= b;
    typed_valid <= typed;
    typed_vis <= vis;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [PLANE_BITS-1:0] data);
    if ($urandom_range(99) < 23) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers may only change with no box in flight.
  task automatic settle_pipe();
    start <= 1'b0;
    while (cull_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  initial begin
    bit prev_cfg;
    logic [MARGIN_BITS-1:0] margin;

    foreach (plane_shadow[p]) plane_shadow[p] = '0;
    margin_shadow = '0;

    // All-zero planes after reset never cull, whatever the box.
    add_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 'h0000, 1'b0), 1'b1, 1'b1);
    add_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768, 'hFFFF, 1'b1), 1'b1, 1'b1);
    add_box(mk_box(0, 0, 0, 0, 0, 0, 'h5A5A, 1'b1), 1'b1, 1'b1);
    // Left keeps x >= 0, right keeps x <= 0.
    add_cfg(REG_PLANE_LEFT, plane_word(16384, 0, 0, 0));
    add_cfg(REG_PLANE_RIGHT, plane_word(-16384, 0, 0, 0));
    add_cfg(REG_CULL_MARGIN, '0);
    add_box(mk_box(-5, 0, 0, -1, 0, 0, 1, 1'b0), 1'b1, 1'b0);
    add_box(mk_box(0, 0, 0, 0, 0, 0, 2, 1'b0), 1'b1, 1'b1);
    add_box(mk_box(1, 0, 0, 5, 0, 0, 3, 1'b0), 1'b1, 1'b0);
    add_box(mk_box(5, 0, 0, -5, 0, 0, 4, 1'b0), 1'b1, 1'b0);
    add_box(mk_box(-5, 0, 0, 5, 0, 0, 5, 1'b1), 1'b1, 1'b1);
    add_cfg(REG_CULL_MARGIN, 16);
    add_box(mk_box(-20, -3, 7, -16, 3, 9, 6, 1'b0), 1'b1, 1'b1);
    add_box(mk_box(17, 0, 0, 20, 0, 0, 7, 1'b0), 1'b1, 1'b0);
    add_cfg(REG_CULL_MARGIN, 32767);
    add_box(mk_box(32767, 0, 0, 32767, 0, 0, 8, 1'b0), 1'b1, 1'b1);
    add_box(mk_box(-32768, 0, 0, -32768, 0, 0, 9, 1'b1), 1'b1, 1'b0);
    // A write to the unused index must leave every register alone.
    add_cfg(REG_SPARE, '1);
    add_box(mk_box(-32768, 0, 0, -32768, 0, 0, 10, 1'b0), 1'b1, 1'b0);
    add_cfg(REG_PLANE_BOTTOM, plane_word(0, 16384, 0, -16));
    add_cfg(REG_PLANE_TOP, plane_word(0, -32768, 0, 32767));
    add_cfg(REG_PLANE_NEAR, plane_word(0, 0, 32767, -32768));
    add_cfg(REG_PLANE_FAR, plane_word(-32768, -32768, -32768, 32767));
    add_cfg(REG_CULL_MARGIN, 8);
    add_box(mk_box(-100, 10, 200, 100, 40, 300, 11, 1'b0), 1'b0, 1'b0);
    add_box(mk_box(-8, 0, 0, 8, 16, 64, 12, 1'b0), 1'b0, 1'b0);
    add_box(mk_box(0, -32768, -32768, 0, 32767, 32767, 13, 1'b1), 1'b0, 1'b0);
    add_box(mk_box(-2000, 100, 500, -1990, 300, 2500, 14, 1'b0), 1'b0, 1'b0);
    add_box(mk_box(50, 8, -400, 60, 24, -100, 15, 1'b0), 1'b0, 1'b0);
    add_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767, 'hFFFF, 1'b1), 1'b0, 1'b0);
    add_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768, 0, 1'b0), 1'b0, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    prev_cfg = 1'b0;
    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        if (!prev_cfg) settle_pipe();
        write_reg(dir_table[i].idx, dir_table[i].data);
      end else begin
        send_box(dir_table[i].box, dir_table[i].typed, dir_table[i].vis);
      end
      prev_cfg = dir_table[i].is_cfg;
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_pipe();
      if (ph == 0) margin = '0;
      else if (ph == 1) margin = '1;
      else if ($urandom_range(3) == 0) margin = MARGIN_BITS'($urandom_range(32767));
      else margin = MARGIN_BITS'($urandom_range(255));
      for (int p = 0; p < NUM_PLANES; p++) write_reg(3'(REG_PLANE_LEFT + p), rand_plane());
      write_reg(REG_CULL_MARGIN, {$urandom, $urandom} & ~64'(MARGIN_BITS'('1)) | margin);
      if ($urandom_range(1) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
      // One phase runs back to back so every transaction follows the last.
      idle_on = (ph != QUIET_PHASE);
      for (int n = 0; n < BOXES_PER_PHASE; n++) send_box(rand_box(), 1'b0, 1'b0);
    end

    settle_pipe();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/afc_pkg.sv
sv/afc_widen.sv
sv/afc_cell.sv
sv/aabb_frustum_cull.sv
dv/aabb_frustum_cull_tb.sv
